@@ src/digraph_compose_table_top_macros.svh @@
// ---------------------------------------------------------------------------
// Digraph compose table assertion macros
// Clocked assertion helpers shared by the table controller and datapath.
// ---------------------------------------------------------------------------
`ifndef DIGRAPH_COMPOSE_TABLE_TOP_MACROS_SVH
`define DIGRAPH_COMPOSE_TABLE_TOP_MACROS_SVH

`ifndef SYNTH
// Assert a property at every rising edge outside reset.
`define DCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Assert that an expression never holds outside reset.
`define DCT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define DCT_ASSERT(lbl, clk, rstn, prop, msg)
`define DCT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ src/dct_pkg.sv @@
// ---------------------------------------------------------------------------
// Digraph compose table package
// Shared types, status codes and the punctuation classifier.
// ---------------------------------------------------------------------------
package dct_pkg;

    localparam int KEY_W    = 8;
    localparam int STATUS_W = 2;

    localparam logic [KEY_W-1:0] CHAR_SET_BIT = 8'h80;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_PUNCT = 2'd1,
        ST_NO_SECOND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_DEFINE = 1'b1
    } kind_t;

    // One table entry: key pair and composed character
    typedef struct packed {
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] second_key;
        logic [KEY_W-1:0] comp_char;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_run;
        logic commit;
    } dct_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dct_stat_t;

    typedef enum logic [2:0] {
        FSM_IDLE   = 3'b001,
        FSM_SCAN   = 3'b010,
        FSM_FINISH = 3'b100
    } fsm_state_t;

    function automatic logic dct_is_punct(input logic [KEY_W-1:0] c);
        logic r;
        r = ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
            ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
        return r;
    endfunction

endpackage

@@ src/digraph_compose_table_top.sv @@
// ---------------------------------------------------------------------------
// Digraph compose table
// Key pair to composed character table with lookup and define transfers.
// ---------------------------------------------------------------------------
// Each input transfer is either a lookup (tuser 0) or a define (tuser 1) and
// gives exactly one output transfer. A lookup returns the character of the
// first live entry whose key pair matches, or the second key when the first
// key is not ASCII punctuation or nothing matches; its status is always ok.
// A define checks the first key (punctuation) and the second key (nonzero),
// sets bit 7 of a nonzero character unless keep_as_typed is set, then
// overwrites the first entry with the same key pair, else the first free
// entry, else reports the table full. Writing a zero character frees an entry.
// The table is empty after reset with no clearing pass: per-entry valid bits
// make unwritten entries read as zero. An item is not accepted until the last
// one has been scanned and committed; the scan reads the table memory one
// entry per cycle. The result sits in an output register, so the next item
// is taken while an earlier result still waits on m_tready.
// ---------------------------------------------------------------------------
module digraph_compose_table_top #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // first_key[7:0], second_key[15:8], new_char[23:16],
                                   // keep_as_typed[24], zero[31:25]
    input  logic        s_tuser,   // kind: 0 lookup, 1 define
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // out_char[7:0], status[9:8], zero[15:10]
);
    import dct_pkg::*;

    dct_cmd_t         cmd;
    dct_stat_t        stat;
    logic [KEY_W-1:0] out_char;
    logic [1:0]       out_status;

    // Sequence the item: accept, scan, commit
    dct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table, scan trackers and result register
    dct_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_kind          (s_tuser),
        .in_first_key     (s_tdata[7:0]),
        .in_second_key    (s_tdata[15:8]),
        .in_new_char      (s_tdata[23:16]),
        .in_keep_as_typed (s_tdata[24]),
        .cmd              (cmd),
        .stat             (stat),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .out_char         (out_char),
        .out_status       (out_status)
    );

    // Pack the result, zero fill to whole bytes
    assign m_tdata = {6'b0, out_status, out_char};

endmodule

@@ src/dct_datapath.sv @@
// ---------------------------------------------------------------------------
// Digraph compose table datapath
// Table memory with valid bits, scan pipeline, match trackers, result register.
// ---------------------------------------------------------------------------
`include "digraph_compose_table_top_macros.svh"

module dct_datapath #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_kind,
    input  logic [7:0]        in_first_key,
    input  logic [7:0]        in_second_key,
    input  logic [7:0]        in_new_char,
    input  logic              in_keep_as_typed,
    input  dct_pkg::dct_cmd_t cmd,
    output dct_pkg::dct_stat_t stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        out_char,
    output logic [1:0]        out_status
);
    import dct_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);

    // Held item
    logic             kind_reg;
    logic [KEY_W-1:0] k1_reg;
    logic [KEY_W-1:0] k2_reg;
    logic [KEY_W-1:0] ch_reg;
    logic             keep_reg;

    // Table storage
    entry_t                   table_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // Scan pipeline
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic [IDX_W-1:0] rd_addr;
    logic             issue;
    entry_t           rd_entry_reg;
    logic             rd_live_reg;
    logic             eval_valid_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    entry_t           eval_entry;
    logic             key_eq;

    // Trackers
    logic             key_hit_reg;
    logic [IDX_W-1:0] key_idx_reg;
    logic             live_hit_reg;
    logic [KEY_W-1:0] live_char_reg;
    logic             free_hit_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Result
    logic             punct;
    logic [KEY_W-1:0] stored_char;
    logic [KEY_W-1:0] res_char;
    status_t          res_status;
    logic             do_write;
    logic [IDX_W-1:0] slot;
    logic             wr_en;
    logic             out_valid_reg;
    logic [KEY_W-1:0] out_char_reg;
    status_t          out_status_reg;

    assign rd_addr     = rd_idx_reg[IDX_W-1:0];
    assign issue       = cmd.scan_run && (rd_idx_reg < ENTRIES_CNT);
    assign rd_idx_next = rd_idx_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            k1_reg   <= in_first_key;
            k2_reg   <= in_second_key;
            ch_reg   <= in_new_char;
            keep_reg <= in_keep_as_typed;
        end
    end

    // Table memory: one registered read, one write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[slot] <= '{first_key: k1_reg, second_key: k2_reg, comp_char: stored_char};
        if (issue)
            rd_entry_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            rd_live_reg    <= 1'b0;
            eval_valid_reg <= 1'b0;
            eval_idx_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                valid_reg[slot] <= 1'b1;
            if (cmd.load)
                rd_idx_reg <= '0;
            else if (issue)
                rd_idx_reg <= rd_idx_next;
            if (issue)
            begin
                rd_live_reg  <= valid_reg[rd_addr];
                eval_idx_reg <= rd_addr;
            end
            eval_valid_reg <= issue;
        end
    end

    // Unwritten entries read as zero
    assign eval_entry = rd_live_reg ? rd_entry_reg : '0;
    assign key_eq     = (eval_entry.first_key == k1_reg) && (eval_entry.second_key == k2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hit_reg  <= 1'b0;
            live_hit_reg <= 1'b0;
            free_hit_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            key_hit_reg  <= 1'b0;
            live_hit_reg <= 1'b0;
            free_hit_reg <= 1'b0;
        end
        else if (eval_valid_reg)
        begin
            if (key_eq && !key_hit_reg)
                key_hit_reg <= 1'b1;
            if (key_eq && (eval_entry.comp_char != '0) && !live_hit_reg)
                live_hit_reg <= 1'b1;
            if ((eval_entry.comp_char == '0) && !free_hit_reg)
                free_hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_valid_reg)
        begin
            if (key_eq && !key_hit_reg)
                key_idx_reg <= eval_idx_reg;
            if (key_eq && (eval_entry.comp_char != '0) && !live_hit_reg)
                live_char_reg <= eval_entry.comp_char;
            if ((eval_entry.comp_char == '0) && !free_hit_reg)
                free_idx_reg <= eval_idx_reg;
        end
    end

    assign punct       = dct_is_punct(k1_reg);
    assign stored_char = (keep_reg || (ch_reg == '0)) ? ch_reg : (ch_reg | CHAR_SET_BIT);

    always_comb
    begin
        res_char   = '0;
        res_status = ST_OK;
        do_write   = 1'b0;
        slot       = key_idx_reg;
        if (kind_reg == KIND_LOOKUP)
        begin
            res_char = (punct && live_hit_reg) ? live_char_reg : k2_reg;
        end
        else if (!punct)
        begin
            res_status = ST_NOT_PUNCT;
        end
        else if (k2_reg == '0)
        begin
            res_status = ST_NO_SECOND;
        end
        else if (key_hit_reg || free_hit_reg)
        begin
            slot     = key_hit_reg ? key_idx_reg : free_idx_reg;
            do_write = 1'b1;
            res_char = stored_char;
        end
        else
        begin
            res_status = ST_FULL;
        end
    end

    assign wr_en = cmd.commit && do_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_char_reg   <= res_char;
            out_status_reg <= res_status;
        end
    end

    assign stat.scan_done = eval_valid_reg && (eval_idx_reg == LAST_IDX);
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign m_tvalid       = out_valid_reg;
    assign out_char       = out_char_reg;
    assign out_status     = out_status_reg;

    `DCT_ASSERT(a_eval_in_range, clk, rst_n, eval_valid_reg |-> (eval_idx_reg <= LAST_IDX), "scan evaluated an entry past the table end")
    `DCT_NEVER(a_commit_drained, clk, rst_n, cmd.commit && (eval_valid_reg || issue), "result committed before the scan drained")
    `DCT_ASSERT(a_load_clears, clk, rst_n, cmd.load |=> ((rd_idx_reg == '0) && !key_hit_reg && !live_hit_reg && !free_hit_reg), "new item did not restart the scan")

endmodule

@@ src/dct_ctrl.sv @@
// ---------------------------------------------------------------------------
// Digraph compose table controller
// Sequences accept, table scan and result commit for one item at a time.
// ---------------------------------------------------------------------------
`include "digraph_compose_table_top_macros.svh"

module dct_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dct_pkg::dct_stat_t stat,
    output dct_pkg::dct_cmd_t  cmd
);
    import dct_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FSM_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.scan_run = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                    state_next = FSM_FINISH;
            end
            FSM_FINISH:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    `DCT_ASSERT(a_finish_after_scan, clk, rst_n, ((state_reg == FSM_FINISH) && ($past(state_reg) == FSM_SCAN)) |-> $past(stat.scan_done), "left scan before the last entry was checked")
    `DCT_NEVER(a_no_load_busy, clk, rst_n, cmd.load && (cmd.scan_run || cmd.commit), "item loaded while a scan or commit is active")

endmodule
